### rtl/tccw_pkg.sv
// Package for the text console character writer.
// Holds the screen geometry, the character and command codes and the command record
// shared by the front, the queue and the back end, plus helper functions for the back end.
`default_nettype none

package tccw_pkg;

  localparam int SCREEN_COLUMNS = 80;
  localparam int SCREEN_ROWS    = 25;
  localparam int TAB_SPACES     = 4;

  localparam int CELLS   = SCREEN_COLUMNS * SCREEN_ROWS;
  localparam int COL_W   = $clog2(SCREEN_COLUMNS + 1);
  localparam int CIDX_W  = $clog2(SCREEN_COLUMNS);
  localparam int ROW_W   = $clog2(SCREEN_ROWS + 1);
  localparam int PROW_W  = $clog2(SCREEN_ROWS);
  localparam int ADDR_W  = $clog2(CELLS);
  localparam int CNT_W   = $clog2(TAB_SPACES + 1);

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
  localparam logic [7:0] CHAR_TAB     = 8'h09;
  localparam logic [7:0] CHAR_SPACE   = 8'h20;

  localparam logic [1:0] CMD_PUT   = 2'd0;
  localparam logic [1:0] CMD_CLEAR = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;

  localparam logic [7:0] ATTR_RESET = 8'd10;

  typedef enum logic [2:0] {
    OP_PUT   = 3'd0,
    OP_NL    = 3'd1,
    OP_CLEAR = 3'd2,
    OP_READ  = 3'd3,
    OP_NOP   = 3'd4
  } op_e;

  typedef struct packed {
    op_e              op;
    logic [7:0]       ch;
    logic [CNT_W-1:0] cnt;
    logic [4:0]       row;
    logic [6:0]       col;
  } cmd_t;

  function automatic logic [PROW_W-1:0] phys_row(input logic [PROW_W-1:0] top,
                                                  input logic [ROW_W-1:0]  row);
    logic [ROW_W:0] sum;
    sum = (ROW_W + 1)'(top) + (ROW_W + 1)'(row);
    if (sum >= (ROW_W + 1)'(SCREEN_ROWS)) begin
      sum = sum - (ROW_W + 1)'(SCREEN_ROWS);
    end
    return sum[PROW_W-1:0];
  endfunction

  function automatic logic [ADDR_W-1:0] cell_addr(input logic [PROW_W-1:0] prow,
                                                   input logic [CIDX_W-1:0] col);
    return ADDR_W'(prow) * ADDR_W'(SCREEN_COLUMNS) + ADDR_W'(col);
  endfunction

endpackage

`default_nettype wire

### rtl/text_console_char_writer.sv
// Top level of the text console character writer.
// Connects tccw_front, tccw_fifo and tccw_back; depends on tccw_pkg.
//
// An 80 by 25 screen of 16-bit cells (attribute high, character low) with a
// cursor, driven by put-character, clear and read-cell commands, one result
// per command in command order. Commands enter a four-deep queue, so the
// input takes commands until it fills while a result waits to be popped.
// The back end executes one command at a time: a character, or the four
// spaces of a tab, go through the put state and a newline through the
// newline state, each wrap or scroll adding a pass; a read goes through the
// registered screen memory port; a clear goes straight to the result, as
// scrolling and clearing reset per-row fill counts rather than sweeping the
// memory. There is no clearing pass after reset. The attribute register is
// always ready and should be written only while no command is in flight.
`default_nettype none

module text_console_char_writer import tccw_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  command_i,
  input  logic [7:0]  char_code_i,
  input  logic [4:0]  cell_row_i,
  input  logic [6:0]  cell_col_i,
  output logic        empty,
  input  logic        pop,
  output logic [15:0] read_data_o,
  output logic [6:0]  cursor_column_o,
  output logic [4:0]  cursor_row_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [7:0]  cfg_data_i
);

  logic enq;
  cmd_t enq_entry;
  logic q_full;
  logic q_empty;
  logic q_deq;
  cmd_t q_entry;
  logic res_valid;

  assign full        = q_full;
  assign empty       = !res_valid;
  assign cfg_ready_o = 1'b1;

  tccw_front u_front (
    .push_i      (push),
    .q_full_i    (q_full),
    .command_i   (command_i),
    .char_code_i (char_code_i),
    .cell_row_i  (cell_row_i),
    .cell_col_i  (cell_col_i),
    .enq_o       (enq),
    .entry_o     (enq_entry)
  );

  tccw_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .enq_i   (enq),
    .data_i  (enq_entry),
    .full_o  (q_full),
    .deq_i   (q_deq),
    .empty_o (q_empty),
    .data_o  (q_entry)
  );

  tccw_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_data_i      (cfg_data_i),
    .q_empty_i       (q_empty),
    .q_data_i        (q_entry),
    .q_deq_o         (q_deq),
    .pop_i           (pop),
    .res_valid_o     (res_valid),
    .read_data_o     (read_data_o),
    .cursor_column_o (cursor_column_o),
    .cursor_row_o    (cursor_row_o)
  );

endmodule

`default_nettype wire

### rtl/tccw_front.sv
// Front end of the text console writer: takes in a command and classifies it.
// Produces one queue record per command; depends on tccw_pkg.
`default_nettype none

module tccw_front import tccw_pkg::*; (
  input  logic       push_i,
  input  logic       q_full_i,
  input  logic [1:0] command_i,
  input  logic [7:0] char_code_i,
  input  logic [4:0] cell_row_i,
  input  logic [6:0] cell_col_i,
  output logic       enq_o,
  output cmd_t       entry_o
);

  assign enq_o = push_i && !q_full_i;

  always_comb begin
    entry_o.ch  = char_code_i;
    entry_o.cnt = CNT_W'(1);
    entry_o.row = cell_row_i;
    entry_o.col = cell_col_i;
    unique case (command_i)
      CMD_PUT: begin
        if (char_code_i == CHAR_NEWLINE) begin
          entry_o.op = OP_NL;
        end else if (char_code_i == CHAR_TAB) begin
          entry_o.op  = OP_PUT;
          entry_o.ch  = CHAR_SPACE;
          entry_o.cnt = CNT_W'(TAB_SPACES);
        end else begin
          entry_o.op = OP_PUT;
        end
      end
      CMD_CLEAR: entry_o.op = OP_CLEAR;
      CMD_READ:  entry_o.op = OP_READ;
      default:   entry_o.op = OP_NOP;
    endcase
  end

endmodule

`default_nettype wire

### rtl/tccw_fifo.sv
// Short command queue between the front end and the back end.
// Stores classified command records; depends on tccw_pkg.
`default_nettype none

module tccw_fifo import tccw_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic enq_i,
  input  cmd_t data_i,
  output logic full_o,
  input  logic deq_i,
  output logic empty_o,
  output cmd_t data_o
);

  cmd_t              entries_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QPTR_W:0]   count_q, count_d;
  logic              do_enq, do_deq;

  assign full_o  = (count_q == (QPTR_W + 1)'(QUEUE_DEPTH));
  assign empty_o = (count_q == '0);
  assign data_o  = entries_q[rd_ptr_q];
  assign do_enq  = enq_i && !full_o;
  assign do_deq  = deq_i && !empty_o;

  always_comb begin
    wr_ptr_d = do_enq ? wr_ptr_q + QPTR_W'(1) : wr_ptr_q;
    rd_ptr_d = do_deq ? rd_ptr_q + QPTR_W'(1) : rd_ptr_q;
    count_d  = count_q;
    if (do_enq && !do_deq) begin
      count_d = count_q + (QPTR_W + 1)'(1);
    end else if (do_deq && !do_enq) begin
      count_d = count_q - (QPTR_W + 1)'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_enq) begin
      entries_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

`default_nettype wire

### rtl/tccw_back.sv
// Back end of the text console writer: cursor, scrolling, screen memory and result.
// Executes queued command records one at a time; depends on tccw_pkg.
`default_nettype none

module tccw_back import tccw_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  input  logic [7:0]  cfg_data_i,
  input  logic        q_empty_i,
  input  cmd_t        q_data_i,
  output logic        q_deq_o,
  input  logic        pop_i,
  output logic        res_valid_o,
  output logic [15:0] read_data_o,
  output logic [6:0]  cursor_column_o,
  output logic [4:0]  cursor_row_o
);

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_PUT   = 6'b000010,
    ST_NL    = 6'b000100,
    ST_READ  = 6'b001000,
    ST_RDATA = 6'b010000,
    ST_DONE  = 6'b100000
  } state_e;

  state_e             state_q, state_d;
  logic [COL_W-1:0]   col_q, col_d;
  logic [ROW_W-1:0]   row_q, row_d;
  logic [PROW_W-1:0]  top_q, top_d;
  logic [COL_W-1:0]   fill_q [SCREEN_ROWS];
  logic [7:0]         attr_q;
  logic [7:0]         ch_q, ch_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic [4:0]         rd_row_q, rd_row_d;
  logic [6:0]         rd_col_q, rd_col_d;
  logic               hit_q, hit_d;
  logic [15:0]        data_q, data_d;
  logic [15:0]        mem_q [CELLS];
  logic [15:0]        mem_rd_q;
  logic               res_valid_q, res_valid_d;
  logic [15:0]        res_data_q;
  logic [6:0]         res_col_q;
  logic [4:0]         res_row_q;
  logic               res_load;

  logic               mem_we;
  logic               fill_set, fill_clr_one, fill_clr_all;
  logic [PROW_W-1:0]  put_prow;
  logic [ADDR_W-1:0]  put_addr;
  logic               rd_in_range;
  logic [PROW_W-1:0]  rd_prow;
  logic [ADDR_W-1:0]  rd_addr;

  assign put_prow    = phys_row(top_q, row_q);
  assign put_addr    = cell_addr(put_prow, col_q[CIDX_W-1:0]);
  assign rd_in_range = (rd_row_q < ROW_W'(SCREEN_ROWS)) && (rd_col_q < COL_W'(SCREEN_COLUMNS));
  assign rd_prow     = rd_in_range ? phys_row(top_q, ROW_W'(rd_row_q)) : '0;
  assign rd_addr     = rd_in_range ? cell_addr(rd_prow, rd_col_q[CIDX_W-1:0]) : '0;

  assign q_deq_o         = (state_q == ST_IDLE) && !q_empty_i;
  assign res_valid_o     = res_valid_q;
  assign read_data_o     = res_data_q;
  assign cursor_column_o = res_col_q;
  assign cursor_row_o    = res_row_q;

  always_comb begin
    state_d      = state_q;
    col_d        = col_q;
    row_d        = row_q;
    top_d        = top_q;
    ch_d         = ch_q;
    cnt_d        = cnt_q;
    rd_row_d     = rd_row_q;
    rd_col_d     = rd_col_q;
    hit_d        = hit_q;
    data_d       = data_q;
    mem_we       = 1'b0;
    fill_set     = 1'b0;
    fill_clr_one = 1'b0;
    fill_clr_all = 1'b0;
    res_load     = 1'b0;
    res_valid_d  = res_valid_q && !pop_i;

    unique case (state_q)
      ST_IDLE: begin
        if (!q_empty_i) begin
          ch_d     = q_data_i.ch;
          cnt_d    = q_data_i.cnt;
          rd_row_d = q_data_i.row;
          rd_col_d = q_data_i.col;
          data_d   = '0;
          unique case (q_data_i.op)
            OP_PUT:  state_d = ST_PUT;
            OP_NL:   state_d = ST_NL;
            OP_READ: state_d = ST_READ;
            OP_CLEAR: begin
              fill_clr_all = 1'b1;
              top_d        = '0;
              col_d        = '0;
              row_d        = '0;
              state_d      = ST_DONE;
            end
            default: state_d = ST_DONE;
          endcase
        end
      end
      ST_PUT: begin
        if (col_q >= COL_W'(SCREEN_COLUMNS) || row_q >= ROW_W'(SCREEN_ROWS)) begin
          if (row_q >= ROW_W'(SCREEN_ROWS)) begin
            fill_clr_one = 1'b1;
            top_d = (top_q == PROW_W'(SCREEN_ROWS - 1)) ? '0 : top_q + PROW_W'(1);
            row_d = ROW_W'(SCREEN_ROWS - 1);
          end else begin
            row_d = row_q + ROW_W'(1);
            col_d = '0;
          end
        end else begin
          mem_we   = 1'b1;
          fill_set = 1'b1;
          col_d    = col_q + COL_W'(1);
          cnt_d    = cnt_q - CNT_W'(1);
          if (cnt_q == CNT_W'(1)) begin
            state_d = ST_DONE;
          end
        end
      end
      ST_NL: begin
        if (row_q >= ROW_W'(SCREEN_ROWS)) begin
          fill_clr_one = 1'b1;
          top_d = (top_q == PROW_W'(SCREEN_ROWS - 1)) ? '0 : top_q + PROW_W'(1);
          row_d = ROW_W'(SCREEN_ROWS - 1);
        end else begin
          row_d   = row_q + ROW_W'(1);
          col_d   = '0;
          state_d = ST_DONE;
        end
      end
      ST_READ: begin
        hit_d   = rd_in_range && (rd_col_q < fill_q[rd_prow]);
        state_d = ST_RDATA;
      end
      ST_RDATA: begin
        data_d  = hit_q ? mem_rd_q : '0;
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (!res_valid_q || pop_i) begin
          res_load    = 1'b1;
          res_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      col_q       <= '0;
      row_q       <= '0;
      top_q       <= '0;
      attr_q      <= ATTR_RESET;
      res_valid_q <= 1'b0;
      for (int i = 0; i < SCREEN_ROWS; i++) begin
        fill_q[i] <= '0;
      end
    end else begin
      state_q     <= state_d;
      col_q       <= col_d;
      row_q       <= row_d;
      top_q       <= top_d;
      res_valid_q <= res_valid_d;
      if (cfg_valid_i) begin
        attr_q <= cfg_data_i;
      end
      if (fill_clr_all) begin
        for (int i = 0; i < SCREEN_ROWS; i++) begin
          fill_q[i] <= '0;
        end
      end else if (fill_clr_one) begin
        fill_q[top_q] <= '0;
      end else if (fill_set) begin
        fill_q[put_prow] <= col_q + COL_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    ch_q     <= ch_d;
    cnt_q    <= cnt_d;
    rd_row_q <= rd_row_d;
    rd_col_q <= rd_col_d;
    hit_q    <= hit_d;
    data_q   <= data_d;
    if (res_load) begin
      res_data_q <= data_q;
      res_col_q  <= 7'(col_q);
      res_row_q  <= 5'(row_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[put_addr] <= {attr_q, ch_q};
    end
    mem_rd_q <= mem_q[rd_addr];
  end

endmodule

`default_nettype wire

### rtl/tccw_checker.sv
// Port-level checker for the text console character writer and its bind.
// Watches the result side of the top level; depends on tccw_pkg.
`default_nettype none

module tccw_checker import tccw_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        empty,
  input logic        pop,
  input logic [15:0] read_data_o,
  input logic [6:0]  cursor_column_o,
  input logic [4:0]  cursor_row_o
);

  a_col_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> cursor_column_o <= 7'(SCREEN_COLUMNS))
    else $error("Cursor column beyond the pending-wrap value.");

  a_row_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> cursor_row_o <= 5'(SCREEN_ROWS))
    else $error("Cursor row beyond the pending-scroll value.");

  a_scroll_col: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && cursor_row_o == 5'(SCREEN_ROWS)) |-> cursor_column_o == 7'd0)
    else $error("Pending scroll with a nonzero cursor column.");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(read_data_o) && $stable(cursor_column_o)
                          && $stable(cursor_row_o)))
    else $error("Result transaction changed while stalled.");

endmodule

bind text_console_char_writer tccw_checker u_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .empty           (empty),
  .pop             (pop),
  .read_data_o     (read_data_o),
  .cursor_column_o (cursor_column_o),
  .cursor_row_o    (cursor_row_o)
);

`default_nettype wire

### bench/tb_text_console_char_writer.sv
// Self-checking testbench for text_console_char_writer, the 80 by 25 text console.
// Contains its own model of the screen and cursor inside a small scoreboard class.
// Depends on tccw_pkg and the RTL of the block; it reads no files.
`timescale 1ns / 1ps

module tb_text_console_char_writer import tccw_pkg::*; ();

  localparam logic [1:0] CMD_UNUSED   = 2'd3;
  localparam int         IDLE_LIMIT   = 5000;
  localparam int         DRAIN_CYCLES = 20;
  localparam int         HOLD_CYCLES  = 200;

  typedef struct packed {
    logic [15:0] data;
    logic [6:0]  col;
    logic [4:0]  row;
  } console_result_t;

  class console_scoreboard;
    logic [15:0]     cells [SCREEN_ROWS * SCREEN_COLUMNS];
    int unsigned     top_row;
    int unsigned     cur_col;
    int unsigned     cur_row;
    logic [7:0]      attribute;
    console_result_t expected_q [$];
    int unsigned     error_count;

    function new();
      clear_all();
      attribute = ATTR_RESET;
      error_count = 0;
    endfunction

    function void clear_all();
      foreach (cells[i]) cells[i] = '0;
      top_row = 0;
      cur_col = 0;
      cur_row = 0;
    endfunction

    function void set_attribute(logic [7:0] value);
      attribute = value;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function int unsigned cell_at(int unsigned r, int unsigned c);
      int unsigned p;
      p = top_row + r;
      if (p >= SCREEN_ROWS) p -= SCREEN_ROWS;
      return p * SCREEN_COLUMNS + c;
    endfunction

    function void scroll_up();
      top_row++;
      if (top_row >= SCREEN_ROWS) top_row = 0;
      for (int c = 0; c < SCREEN_COLUMNS; c++) cells[cell_at(SCREEN_ROWS - 1, c)] = '0;
      cur_row = SCREEN_ROWS - 1;
    endfunction

    function void line_feed();
      if (cur_row >= SCREEN_ROWS) scroll_up();
      cur_row++;
      cur_col = 0;
    endfunction

    function void write_char(logic [7:0] ch);
      if (cur_col > SCREEN_COLUMNS - 1) line_feed();
      if (cur_row > SCREEN_ROWS - 1) scroll_up();
      cells[cell_at(cur_row, cur_col)] = {attribute, ch};
      cur_col++;
    endfunction

    function void note_command(logic [1:0] cmd, logic [7:0] ch, logic [4:0] row,
                               logic [6:0] col);
      console_result_t res;
      res.data = '0;
      case (cmd)
        CMD_PUT: begin
          if (ch == CHAR_NEWLINE) begin
            line_feed();
          end else if (ch == CHAR_TAB) begin
            for (int i = 0; i < TAB_SPACES; i++) write_char(CHAR_SPACE);
          end else begin
            write_char(ch);
          end
        end
        CMD_CLEAR: clear_all();
        CMD_READ: begin
          if (row < SCREEN_ROWS && col < SCREEN_COLUMNS) res.data = cells[cell_at(row, col)];
        end
        default: ;
      endcase
      res.col = 7'(cur_col);
      res.row = 5'(cur_row);
      expected_q.push_back(res);
    endfunction

    function void check_result(logic [15:0] data, logic [6:0] col, logic [4:0] row);
      console_result_t exp_res;
      if (expected_q.size() == 0) begin
        $error("Unexpected result: read_data %h, cursor_column %0d, cursor_row %0d",
               data, col, row);
        error_count++;
        return;
      end
      exp_res = expected_q.pop_front();
      if (data !== exp_res.data) begin
        $error("read_data mismatch: expected %h, actual %h", exp_res.data, data);
        error_count++;
      end
      if (col !== exp_res.col) begin
        $error("cursor_column mismatch: expected %0d, actual %0d", exp_res.col, col);
        error_count++;
      end
      if (row !== exp_res.row) begin
        $error("cursor_row mismatch: expected %0d, actual %0d", exp_res.row, row);
        error_count++;
      end
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        push;
  logic        full;
  logic [1:0]  command_i;
  logic [7:0]  char_code_i;
  logic [4:0]  cell_row_i;
  logic [6:0]  cell_col_i;
  logic        empty;
  logic        pop;
  logic [15:0] read_data_o;
  logic [6:0]  cursor_column_o;
  logic [4:0]  cursor_row_o;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [7:0]  cfg_data_i;

  console_scoreboard sb = new();

  bit          hold_request = 0;
  int unsigned burst_left = 0;
  bit          steady = 0;
  int unsigned idle_count = 0;

  text_console_char_writer DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push           (push),
    .full           (full),
    .command_i      (command_i),
    .char_code_i    (char_code_i),
    .cell_row_i     (cell_row_i),
    .cell_col_i     (cell_col_i),
    .empty          (empty),
    .pop            (pop),
    .read_data_o    (read_data_o),
    .cursor_column_o(cursor_column_o),
    .cursor_row_o   (cursor_row_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_data_i     (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    int unsigned pop_percent;
    int unsigned mode_left;
    int unsigned hold_cycles;
    bit          hold_served;
    pop_percent = 100;
    mode_left = 0;
    hold_cycles = 0;
    hold_served = 1'b0;
    pop = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_request && !hold_served) begin
        hold_cycles = HOLD_CYCLES;
        hold_served = 1'b1;
      end
      if (hold_cycles > 0) begin
        pop = 1'b0;
        hold_cycles--;
      end else begin
        if (mode_left == 0) begin
          case ($urandom_range(0, 3))
            0: pop_percent = 100;
            1: pop_percent = 75;
            2: pop_percent = 40;
            default: pop_percent = 10;
          endcase
          mode_left = $urandom_range(5, 60);
        end
        mode_left--;
        pop = ($urandom_range(0, 99) < pop_percent);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      idle_count++;
      if (pop && !empty) begin
        sb.check_result(read_data_o, cursor_column_o, cursor_row_o);
        idle_count = 0;
      end
      if (push && !full) begin
        sb.note_command(command_i, char_code_i, cell_row_i, cell_col_i);
        idle_count = 0;
      end
      if (idle_count >= IDLE_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  task automatic send_item(input logic [1:0] cmd, input logic [7:0] ch,
                           input logic [4:0] row, input logic [6:0] col);
    int unsigned gap;
    if (!steady && burst_left == 0) begin
      gap = $urandom_range(1, 12);
      @(negedge clk_i);
      push = 1'b0;
      repeat (gap - 1) @(negedge clk_i);
      burst_left = $urandom_range(1, 40);
    end
    if (burst_left > 0) burst_left--;
    @(negedge clk_i);
    push = 1'b1;
    command_i = cmd;
    char_code_i = ch;
    cell_row_i = row;
    cell_col_i = col;
    do @(posedge clk_i); while (full);
  endtask

  task automatic put_char(input logic [7:0] ch);
    send_item(CMD_PUT, ch, 5'($urandom), 7'($urandom));
  endtask

  task automatic wait_for_results();
    @(negedge clk_i);
    push = 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  task automatic write_attribute(input logic [7:0] value);
    wait_for_results();
    @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_data_i = value;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.set_attribute(value);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  task automatic random_text(input int unsigned count);
    int unsigned sent;
    int unsigned pick;
    int unsigned len;
    logic [4:0]  row;
    logic [6:0]  col;
    sent = 0;
    while (sent < count) begin
      pick = $urandom_range(0, 999);
      if (pick < 30) begin
        len = $urandom_range(60, 100);
        repeat (len) put_char(8'($urandom_range(32, 126)));
        sent += len;
      end else if (pick < 970) begin
        if (pick < 530) begin
          put_char(8'($urandom_range(32, 126)));
        end else if (pick < 600) begin
          put_char(8'($urandom));
        end else if (pick < 720) begin
          put_char(CHAR_NEWLINE);
        end else if (pick < 790) begin
          put_char(CHAR_TAB);
        end else if (pick < 940) begin
          case ($urandom_range(0, 3))
            0, 1: begin
              row = 5'($urandom_range(0, SCREEN_ROWS - 1));
              col = 7'($urandom_range(0, SCREEN_COLUMNS - 1));
            end
            2: begin
              row = 5'((sb.cur_row > SCREEN_ROWS - 1) ? SCREEN_ROWS - 1 : sb.cur_row);
              col = 7'((sb.cur_col == 0) ? 0 : sb.cur_col - 1);
              if (col > SCREEN_COLUMNS - 1) col = SCREEN_COLUMNS - 1;
            end
            default: begin
              row = 5'($urandom);
              col = 7'($urandom);
            end
          endcase
          send_item(CMD_READ, 8'($urandom), row, col);
        end else if (pick < 965) begin
          send_item(CMD_UNUSED, 8'($urandom), 5'($urandom), 7'($urandom));
        end else begin
          send_item(CMD_CLEAR, 8'($urandom), 5'($urandom), 7'($urandom));
        end
        sent++;
      end else begin
        len = $urandom_range(3, 30);
        repeat (len) put_char(CHAR_NEWLINE);
        sent += len;
      end
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    push = 1'b0;
    command_i = CMD_PUT;
    char_code_i = '0;
    cell_row_i = '0;
    cell_col_i = '0;
    cfg_valid_i = 1'b0;
    cfg_data_i = '0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    send_item(CMD_READ, 8'h00, 5'd0, 7'd0);
    put_char(8'h41);
    put_char(8'hFF);
    put_char(8'h00);
    put_char(CHAR_TAB);
    put_char(8'h80);
    put_char(CHAR_NEWLINE);
    send_item(CMD_READ, 8'h00, 5'd0, 7'd0);
    send_item(CMD_READ, 8'h00, 5'd0, 7'd2);
    send_item(CMD_READ, 8'h00, 5'd0, 7'd5);
    send_item(CMD_READ, 8'h00, 5'd0, 7'd7);
    send_item(CMD_READ, 8'hFF, 5'd31, 7'd127);
    send_item(CMD_READ, 8'h00, 5'd25, 7'd0);
    send_item(CMD_READ, 8'h00, 5'd0, 7'd80);
    send_item(CMD_READ, 8'h00, 5'd24, 7'd79);
    send_item(CMD_UNUSED, 8'hFF, 5'd31, 7'd127);
    put_char(8'h7F);
    send_item(CMD_READ, 8'h00, 5'd1, 7'd0);
    send_item(CMD_CLEAR, 8'h00, 5'd0, 7'd0);
    send_item(CMD_READ, 8'h00, 5'd0, 7'd0);
    send_item(CMD_READ, 8'h00, 5'd1, 7'd0);
    put_char(CHAR_NEWLINE);

    write_attribute(8'hFF);
    random_text(60);
    @(posedge clk_i);
    hold_request = 1'b1;
    steady = 1;
    random_text(30);
    steady = 0;
    random_text(120);

    write_attribute(8'h00);
    random_text(200);

    write_attribute(8'($urandom));
    random_text(200);

    wait_for_results();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (sb.error_count == 0 && sb.pending() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

### sim.f
rtl/tccw_pkg.sv
rtl/tccw_front.sv
rtl/tccw_fifo.sv
rtl/tccw_back.sv
rtl/text_console_char_writer.sv
rtl/tccw_checker.sv
bench/tb_text_console_char_writer.sv
